@@ hdl/fula_pkg.sv @@
package fula_pkg;

    // field and register widths
    localparam int NUM_UNITS_W = 9;
    localparam int UNIT_SIZE_W = 21;
    localparam int REQ_SIZE_W  = 24;
    localparam int INDEX_W     = 9;
    localparam int STATUS_W    = 2;
    localparam int GRANT_W     = 8;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 8;
    localparam int CFG_INDEX_W = 1;

    // default pool storage
    localparam int DEFAULT_MAX_UNITS = 256;

    // register reset values
    localparam logic [NUM_UNITS_W-1:0] RST_NUM_UNITS = 9'd50;
    localparam logic [UNIT_SIZE_W-1:0] RST_UNIT_SIZE = 21'd1024;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_NUM_UNITS = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_UNIT_SIZE = 1'b1;

    // command codes
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] STATUS_GRANT     = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_SYS_ALLOC = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_RETURNED  = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_SYS_FREE  = 2'd3;

    // sequencer states
    typedef enum logic [1:0] {
        S_SWEEP,
        S_IDLE,
        S_POP,
        S_HOLD
    } state_t;

endpackage

@@ hdl/fula_link_mem.sv @@
module fula_link_mem #(
    parameter int DEPTH = fula_pkg::DEFAULT_MAX_UNITS,
    parameter int AW    = $clog2(DEPTH),
    parameter int DW    = AW + 1
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port, holds its data between reads
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/fixed_unit_free_list_allocator.sv @@
// Fixed-unit free-list allocator.
// Requests arrive on the s_ channel: s_tuser is the command (allocate or
// free), s_tdata carries req_size, use_pool and unit_index. Each request
// gives exactly one result on the m_ channel: m_tuser is the status, m_tdata
// the granted unit index (zero unless a pool unit was granted).
// Configuration is written through cfg_we / cfg_index / cfg_wdata; the user
// must write it only while the block is idle, which the block itself does
// not enforce; writing num_units rebuilds the free list.
// A free or fallback result is registered on its transfer; a pool grant is
// registered in the pop state, after the link memory read.
// Frees and fallbacks are taken one request a cycle while the receiver keeps
// up; a pool grant holds s_tready low in the pop state as the head moves on.
// Reset and every num_units write start a rebuild sweep over the first
// min(num_units, MAX_UNITS) link memory entries, with s_tready low.
// A stalled receiver holds the result in the output register; one more
// result waits in a skid register, after which s_tready drops.
module fixed_unit_free_list_allocator #(
    parameter int MAX_UNITS = fula_pkg::DEFAULT_MAX_UNITS
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // request: s_tdata = req_size[23:0], use_pool[24], unit_index[33:25]
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [fula_pkg::IN_TDATA_W-1:0]      s_tdata,
    // s_tuser = cmd
    input  logic                                 s_tuser,
    // result: m_tdata = granted_index[7:0]
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [fula_pkg::OUT_TDATA_W-1:0]     m_tdata,
    // m_tuser = status[1:0]
    output logic [fula_pkg::STATUS_W-1:0]        m_tuser,
    // configuration write port
    input  logic                                 cfg_we,
    input  logic [fula_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [fula_pkg::UNIT_SIZE_W-1:0]     cfg_wdata
);

    localparam int IW = $clog2(MAX_UNITS);
    localparam int CW = $clog2(MAX_UNITS + 1);
    localparam int WW = (CW > fula_pkg::INDEX_W) ? CW : fula_pkg::INDEX_W;
    localparam int GW = (IW > fula_pkg::GRANT_W) ? IW : fula_pkg::GRANT_W;
    localparam int DW = IW + 1;
    localparam int RST_NEFF = (int'(fula_pkg::RST_NUM_UNITS) > MAX_UNITS) ?
                              MAX_UNITS : int'(fula_pkg::RST_NUM_UNITS);

    fula_pkg::state_t state_reg, state_next;

    logic [CW-1:0]                    n_eff_reg, n_eff_next;
    logic [fula_pkg::UNIT_SIZE_W-1:0] unit_size_reg, unit_size_next;
    logic [IW-1:0]                    head_reg, head_next;
    logic                             head_valid_reg, head_valid_next;
    logic [CW-1:0]                    sweep_reg, sweep_next;

    logic                             out_valid_reg, out_valid_next;
    logic [fula_pkg::STATUS_W-1:0]    out_status_reg, out_status_next;
    logic [fula_pkg::GRANT_W-1:0]     out_index_reg, out_index_next;
    logic [fula_pkg::STATUS_W-1:0]    pend_status_reg, pend_status_next;
    logic [fula_pkg::GRANT_W-1:0]     pend_index_reg, pend_index_next;

    // request fields
    logic                             in_cmd;
    logic [fula_pkg::REQ_SIZE_W-1:0]  in_req;
    logic                             in_use;
    logic [fula_pkg::INDEX_W-1:0]     in_idx;

    logic                             accept;
    logic                             slot_free;
    logic                             alloc_ok;
    logic                             free_ok;
    logic                             pop_now;
    logic                             imm_now;
    logic                             cfg_num_wr;
    logic [WW-1:0]                    cfg_units_ext;
    logic [CW-1:0]                    cfg_n_eff;
    logic [WW-1:0]                    idx_ext;
    logic [GW-1:0]                    head_wide;
    logic [fula_pkg::STATUS_W-1:0]    imm_status;
    logic [fula_pkg::STATUS_W-1:0]    res_status;
    logic [fula_pkg::GRANT_W-1:0]     res_index;
    logic                             produce;

    // link memory port signals
    logic                             mem_we;
    logic [IW-1:0]                    mem_waddr;
    logic [DW-1:0]                    mem_wdata;
    logic                             mem_re;
    logic [DW-1:0]                    mem_rdata;
    logic [IW-1:0]                    sweep_addr;

    fula_link_mem #(
        .DEPTH (MAX_UNITS),
        .AW    (IW),
        .DW    (DW)
    ) u_link_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (head_reg),
        .rdata (mem_rdata)
    );

    // field unpacking
    assign in_cmd = s_tuser;
    assign in_req = s_tdata[23:0];
    assign in_use = s_tdata[24];
    assign in_idx = s_tdata[33:25];

    // request decode
    assign s_tready  = (state_reg == fula_pkg::S_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign slot_free = !out_valid_reg || m_tready;
    assign alloc_ok  = (in_req <= fula_pkg::REQ_SIZE_W'(unit_size_reg)) && in_use &&
                       (n_eff_reg != '0) && head_valid_reg;
    assign idx_ext   = WW'(in_idx);
    assign free_ok   = idx_ext < WW'(n_eff_reg);
    assign pop_now   = accept && (in_cmd == fula_pkg::CMD_ALLOC) && alloc_ok;
    assign imm_now   = accept && !pop_now;
    assign head_wide = GW'(head_reg);
    assign sweep_addr = sweep_reg[IW-1:0];

    // status of a result that needs no memory read
    always_comb
    begin
        if (in_cmd == fula_pkg::CMD_FREE)
        begin
            imm_status = free_ok ? fula_pkg::STATUS_RETURNED : fula_pkg::STATUS_SYS_FREE;
        end
        else
        begin
            imm_status = fula_pkg::STATUS_SYS_ALLOC;
        end
    end

    // effective unit count of a num_units write
    assign cfg_num_wr    = cfg_we && (cfg_index == fula_pkg::REG_NUM_UNITS);
    assign cfg_units_ext = WW'(cfg_wdata[fula_pkg::NUM_UNITS_W-1:0]);
    assign cfg_n_eff     = (cfg_units_ext > WW'(MAX_UNITS)) ? CW'(MAX_UNITS) :
                           CW'(cfg_units_ext);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            fula_pkg::S_SWEEP:
            begin
                if (sweep_reg >= n_eff_reg)
                begin
                    state_next = fula_pkg::S_IDLE;
                end
            end
            fula_pkg::S_IDLE:
            begin
                if (pop_now)
                begin
                    state_next = fula_pkg::S_POP;
                end
                else if (imm_now && !slot_free)
                begin
                    state_next = fula_pkg::S_HOLD;
                end
            end
            fula_pkg::S_POP:
            begin
                state_next = slot_free ? fula_pkg::S_IDLE : fula_pkg::S_HOLD;
            end
            fula_pkg::S_HOLD:
            begin
                if (slot_free)
                begin
                    state_next = fula_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = fula_pkg::S_SWEEP;
            end
        endcase
        if (cfg_num_wr)
        begin
            state_next = fula_pkg::S_SWEEP;
        end
    end

    // handshake and datapath
    always_comb
    begin
        n_eff_next       = n_eff_reg;
        unit_size_next   = unit_size_reg;
        head_next        = head_reg;
        head_valid_next  = head_valid_reg;
        sweep_next       = sweep_reg;
        out_valid_next   = out_valid_reg;
        out_status_next  = out_status_reg;
        out_index_next   = out_index_reg;
        pend_status_next = pend_status_reg;
        pend_index_next  = pend_index_reg;
        mem_we           = 1'b0;
        mem_waddr        = sweep_addr;
        mem_wdata        = {(sweep_reg == '0), IW'(sweep_addr - 1'b1)};
        mem_re           = 1'b0;

        // result of this cycle, if any
        if (state_reg == fula_pkg::S_POP)
        begin
            res_status = fula_pkg::STATUS_GRANT;
            res_index  = head_wide[fula_pkg::GRANT_W-1:0];
        end
        else
        begin
            res_status = imm_status;
            res_index  = '0;
        end
        produce = (state_reg == fula_pkg::S_POP) || imm_now;

        // rebuild sweep: unit i links to i-1, unit 0 ends the list
        if (state_reg == fula_pkg::S_SWEEP && sweep_reg < n_eff_reg)
        begin
            mem_we     = 1'b1;
            sweep_next = sweep_reg + 1'b1;
        end

        // free pushes the unit on the head
        if (imm_now && in_cmd == fula_pkg::CMD_FREE && free_ok)
        begin
            mem_we          = 1'b1;
            mem_waddr       = idx_ext[IW-1:0];
            mem_wdata       = {!head_valid_reg, head_reg};
            head_next       = idx_ext[IW-1:0];
            head_valid_next = 1'b1;
        end

        // allocate reads the head link, the head moves on in the pop state
        if (pop_now)
        begin
            mem_re = 1'b1;
        end
        if (state_reg == fula_pkg::S_POP)
        begin
            if (mem_rdata[DW-1])
            begin
                head_next       = '0;
                head_valid_next = 1'b0;
            end
            else
            begin
                head_next = mem_rdata[IW-1:0];
            end
        end

        // output register and skid register
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (state_reg == fula_pkg::S_HOLD && slot_free)
        begin
            out_valid_next  = 1'b1;
            out_status_next = pend_status_reg;
            out_index_next  = pend_index_reg;
        end
        else if (produce && slot_free)
        begin
            out_valid_next  = 1'b1;
            out_status_next = res_status;
            out_index_next  = res_index;
        end
        else if (produce)
        begin
            pend_status_next = res_status;
            pend_index_next  = res_index;
        end

        // configuration writes
        if (cfg_num_wr)
        begin
            n_eff_next      = cfg_n_eff;
            head_next       = IW'(cfg_n_eff - 1'b1);
            head_valid_next = (cfg_n_eff != '0);
            sweep_next      = '0;
        end
        if (cfg_we && cfg_index == fula_pkg::REG_UNIT_SIZE)
        begin
            unit_size_next = cfg_wdata;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= fula_pkg::S_SWEEP;
            n_eff_reg      <= CW'(RST_NEFF);
            unit_size_reg  <= fula_pkg::RST_UNIT_SIZE;
            head_reg       <= IW'(RST_NEFF - 1);
            head_valid_reg <= (RST_NEFF != 0);
            sweep_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            n_eff_reg      <= n_eff_next;
            unit_size_reg  <= unit_size_next;
            head_reg       <= head_next;
            head_valid_reg <= head_valid_next;
            sweep_reg      <= sweep_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // result payload registers
    always_ff @(posedge clk)
    begin
        out_status_reg  <= out_status_next;
        out_index_reg   <= out_index_next;
        pend_status_reg <= pend_status_next;
        pend_index_reg  <= pend_index_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = out_index_reg;

`ifndef SYNTHESIS
    // a pop state only follows a transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == fula_pkg::S_POP |-> $past(s_tvalid && s_tready))
    else $error("pop state without a request transfer");

    // the skid register is used only while the output register is full
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == fula_pkg::S_HOLD |-> out_valid_reg)
    else $error("holding a result with an empty output register");

    // the head of a non-empty list lies inside the pool
    assert property (@(posedge clk) disable iff (!rst_n)
        head_valid_reg |-> CW'(head_reg) < n_eff_reg)
    else $error("free list head outside the pool");

    // only a pool grant carries a nonzero index
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != fula_pkg::STATUS_GRANT |-> m_tdata == '0)
    else $error("nonzero index without a pool grant");
`endif

endmodule

@@ tb/fula_checker.sv @@
`timescale 1ns / 100ps

module fula_checker #(
    parameter int MAX_UNITS = fula_pkg::DEFAULT_MAX_UNITS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // request channel
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    // s_tdata = req_size[23:0], use_pool[24], unit_index[33:25]
    input  logic [fula_pkg::IN_TDATA_W-1:0]  s_tdata,
    // s_tuser = cmd
    input  logic                             s_tuser,
    // result channel
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    // m_tdata = granted_index[7:0]
    input  logic [fula_pkg::OUT_TDATA_W-1:0] m_tdata,
    // m_tuser = status[1:0]
    input  logic [fula_pkg::STATUS_W-1:0]    m_tuser,
    // configuration write port
    input  logic                             cfg_we,
    input  logic [fula_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [fula_pkg::UNIT_SIZE_W-1:0] cfg_wdata,
    // verdict and statistics
    output int                               fail_count,
    output int                               pending,
    output int                               grant_count,
    output int                               sys_alloc_count,
    output int                               return_count,
    output int                               sys_free_count
);

    localparam int REQ_W   = fula_pkg::REQ_SIZE_W;
    localparam int IDX_W   = fula_pkg::INDEX_W;
    localparam int GRANT_W = fula_pkg::GRANT_W;

    typedef struct packed {
        logic [fula_pkg::STATUS_W-1:0] status;
        logic [GRANT_W-1:0]            unit;
    } outcome_t;

    // shadow of the pool registers and the free list
    logic [fula_pkg::NUM_UNITS_W-1:0] pool_size_reg;
    logic [fula_pkg::UNIT_SIZE_W-1:0] unit_bytes;
    logic [IDX_W-1:0]                 link_next [MAX_UNITS];
    logic                             link_last [MAX_UNITS];
    logic [IDX_W-1:0]                 head_unit;
    logic                             head_live;
    outcome_t                         outcome_q [$];
    int                               result_no;

    // units actually backed by storage
    function automatic int units_in_use();
        return (pool_size_reg > MAX_UNITS) ? MAX_UNITS : int'(pool_size_reg);
    endfunction

    // chain every unit to the one below it, head at the top unit
    task automatic rebuild_free_list();
        int n;
        n = units_in_use();
        for (int i = 0; i < MAX_UNITS; i++)
        begin
            link_next[i] = (i == 0) ? '0 : IDX_W'(i - 1);
            link_last[i] = (i == 0);
        end
        head_live = (n != 0);
        head_unit = (n != 0) ? IDX_W'(n - 1) : '0;
    endtask

    // apply one request to the free list and work out its result
    task automatic serve_request(
        input  logic              cmd,
        input  logic [REQ_W-1:0]  req_bytes,
        input  logic              pool_ok,
        input  logic [IDX_W-1:0]  unit_idx,
        output outcome_t          res
    );
        int n;
        n = units_in_use();
        res.status = fula_pkg::STATUS_GRANT;
        res.unit   = '0;
        if (cmd == fula_pkg::CMD_ALLOC)
        begin
            // oversize, pool disabled, no pool or empty list all fall back
            if (req_bytes > REQ_W'(unit_bytes) || !pool_ok || n == 0 ||
                !head_live)
            begin
                res.status = fula_pkg::STATUS_SYS_ALLOC;
            end
            else
            begin
                res.unit = head_unit[GRANT_W-1:0];
                if (link_last[head_unit])
                begin
                    head_live = 1'b0;
                    head_unit = '0;
                end
                else
                begin
                    head_unit = link_next[head_unit];
                end
            end
        end
        else if (int'(unit_idx) < n)
        begin
            // push back on the head, double frees included
            link_next[unit_idx] = head_unit;
            link_last[unit_idx] = !head_live;
            head_unit  = unit_idx;
            head_live  = 1'b1;
            res.status = fula_pkg::STATUS_RETURNED;
        end
        else
        begin
            res.status = fula_pkg::STATUS_SYS_FREE;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        outcome_t got;
        outcome_t want;
        if (!rst_n)
        begin
            pool_size_reg = fula_pkg::RST_NUM_UNITS;
            unit_bytes    = fula_pkg::RST_UNIT_SIZE;
            rebuild_free_list();
            outcome_q.delete();
            pending         = 0;
            result_no       = 0;
            fail_count      = 0;
            grant_count     = 0;
            sys_alloc_count = 0;
            return_count    = 0;
            sys_free_count  = 0;
        end
        else
        begin
            // result transfer against the oldest expectation
            if (m_tvalid && m_tready)
            begin
                got.status = m_tuser;
                got.unit   = m_tdata[GRANT_W-1:0];
                result_no++;
                if (outcome_q.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("unexpected result %0d: status %0d unit %0d",
                                 result_no, got.status, got.unit);
                    fail_count++;
                end
                else
                begin
                    want = outcome_q.pop_front();
                    if (got.status !== want.status || got.unit !== want.unit)
                    begin
                        if (fail_count < 10)
                            $display({"result %0d mismatch: expected status %0d unit %0d,",
                                      " got status %0d unit %0d"},
                                     result_no, want.status, want.unit,
                                     got.status, got.unit);
                        fail_count++;
                    end
                end
                case (got.status)
                    fula_pkg::STATUS_GRANT:     grant_count++;
                    fula_pkg::STATUS_SYS_ALLOC: sys_alloc_count++;
                    fula_pkg::STATUS_RETURNED:  return_count++;
                    fula_pkg::STATUS_SYS_FREE:  sys_free_count++;
                    default:                    ;
                endcase
            end

            // register writes
            if (cfg_we)
            begin
                if (cfg_index == fula_pkg::REG_NUM_UNITS)
                begin
                    pool_size_reg = cfg_wdata[fula_pkg::NUM_UNITS_W-1:0];
                    rebuild_free_list();
                end
                else if (cfg_index == fula_pkg::REG_UNIT_SIZE)
                begin
                    unit_bytes = cfg_wdata;
                end
            end

            // request transfer
            if (s_tvalid && s_tready)
            begin
                serve_request(s_tuser, s_tdata[REQ_W-1:0], s_tdata[REQ_W],
                              s_tdata[REQ_W+IDX_W:REQ_W+1], want);
                outcome_q.push_back(want);
            end

            pending = outcome_q.size();
        end
    end

endmodule

@@ tb/fixed_unit_free_list_allocator_tb.sv @@
`timescale 1ns / 100ps

module fixed_unit_free_list_allocator_tb;

    localparam int CLK_HALF    = 4;
    localparam int CYCLE_LIMIT = 200000;

    localparam int REQ_W   = fula_pkg::REQ_SIZE_W;
    localparam int IDX_W   = fula_pkg::INDEX_W;
    localparam int IN_W    = fula_pkg::IN_TDATA_W;
    localparam int OUT_W   = fula_pkg::OUT_TDATA_W;
    localparam int ST_W    = fula_pkg::STATUS_W;
    localparam int CIDX_W  = fula_pkg::CFG_INDEX_W;
    localparam int CDATA_W = fula_pkg::UNIT_SIZE_W;
    localparam int NUM_W   = fula_pkg::NUM_UNITS_W;
    localparam int MAX_U   = fula_pkg::DEFAULT_MAX_UNITS;

    typedef enum logic [1:0] {
        PACE_FULL,
        PACE_SEND_GAPS,
        PACE_RECV_STALLS,
        PACE_BOTH
    } pace_t;

    logic               clk;
    logic               rst_n;
    logic               s_tvalid;
    logic               s_tready;
    // req_size[23:0], use_pool[24], unit_index[33:25]
    logic [IN_W-1:0]    s_tdata;
    // cmd
    logic               s_tuser;
    logic               m_tvalid;
    logic               m_tready = 1'b1;
    // granted_index[7:0]
    logic [OUT_W-1:0]   m_tdata;
    // status[1:0]
    logic [ST_W-1:0]    m_tuser;
    logic               cfg_we;
    logic [CIDX_W-1:0]  cfg_index;
    logic [CDATA_W-1:0] cfg_wdata;

    int fail_count;
    int pending;
    int grant_count;
    int sys_alloc_count;
    int return_count;
    int sys_free_count;

    int gap_pct   = 0;
    int stall_pct = 0;
    int cycles    = 0;
    int pool_units;
    int unit_bytes;
    int sent;
    int settings;

    fixed_unit_free_list_allocator i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    fula_checker i_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .fail_count      (fail_count),
        .pending         (pending),
        .grant_count     (grant_count),
        .sys_alloc_count (sys_alloc_count),
        .return_count    (return_count),
        .sys_free_count  (sys_free_count)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // receiver back-pressure
    always @(negedge clk)
    begin
        m_tready <= ($urandom_range(99, 0) >= stall_pct);
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles with %0d results outstanding", cycles, pending);
            $display("Regression FAIL");
            $finish;
        end
    end

    // one request transfer, with a random idle gap ahead of it
    task automatic send_request(
        input logic             cmd,
        input logic [REQ_W-1:0] req_bytes,
        input logic             pool_ok,
        input logic [IDX_W-1:0] unit_idx
    );
        int gap;
        gap = 0;
        while (gap < 24 && $urandom_range(99, 0) < gap_pct)
            gap++;
        if (gap > 0)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {{(IN_W - IDX_W - 1 - REQ_W){1'b0}},
                     unit_idx, pool_ok, req_bytes};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sent++;
    endtask

    // hold the sender until every result is back
    task automatic drain_results();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    task automatic write_config(
        input logic [CIDX_W-1:0]  index,
        input logic [CDATA_W-1:0] value
    );
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= value;
    endtask

    // new pool settings, written only with the block idle
    task automatic reconfigure(
        input logic               set_units,
        input logic [CDATA_W-1:0] units_word,
        input logic               set_bytes,
        input logic [CDATA_W-1:0] bytes_word
    );
        drain_results();
        repeat (4) @(negedge clk);
        if (set_units)
        begin
            write_config(fula_pkg::REG_NUM_UNITS, units_word);
            pool_units = (units_word[NUM_W-1:0] > MAX_U) ?
                         MAX_U : int'(units_word[NUM_W-1:0]);
        end
        if (set_bytes)
        begin
            write_config(fula_pkg::REG_UNIT_SIZE, bytes_word);
            unit_bytes = int'(bytes_word);
        end
        @(negedge clk);
        cfg_we <= 1'b0;
        settings++;
    endtask

    // mostly well-formed allocates and in-range frees, plus noise
    task automatic random_request();
        int                 pick;
        logic [REQ_W-1:0]   noise_bytes;
        logic [IDX_W-1:0]   noise_index;
        logic               noise_flag;
        pick        = $urandom_range(99, 0);
        noise_bytes = REQ_W'($urandom());
        noise_index = IDX_W'($urandom());
        noise_flag  = 1'($urandom_range(1, 0));
        if (pick < 45)
            send_request(fula_pkg::CMD_ALLOC, REQ_W'($urandom_range(unit_bytes, 0)),
                         1'b1, noise_index);
        else if (pick < 52)
            send_request(fula_pkg::CMD_ALLOC, REQ_W'(unit_bytes + $urandom_range(1, 0)),
                         1'b1, noise_index);
        else if (pick < 62)
            send_request(fula_pkg::CMD_ALLOC, noise_bytes, noise_flag, noise_index);
        else if (pick < 90 && pool_units > 0)
            send_request(fula_pkg::CMD_FREE, noise_bytes, noise_flag,
                         IDX_W'($urandom_range(pool_units - 1, 0)));
        else
            send_request(fula_pkg::CMD_FREE, noise_bytes, noise_flag, noise_index);
    endtask

    task automatic run_phase(input int count, input pace_t pace);
        gap_pct   = (pace == PACE_SEND_GAPS) ? 62 : (pace == PACE_BOTH) ? 20 : 0;
        stall_pct = (pace == PACE_RECV_STALLS) ? 62 : (pace == PACE_BOTH) ? 20 : 0;
        for (int k = 0; k < count; k++)
        begin
            if (k == count / 2 && pace == PACE_SEND_GAPS)
                drain_results();
            random_request();
        end
    endtask

    // stimulus and verdict
    initial
    begin
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = fula_pkg::CMD_ALLOC;
        cfg_we     = 1'b0;
        cfg_index  = fula_pkg::REG_NUM_UNITS;
        cfg_wdata  = '0;
        pool_units = int'(fula_pkg::RST_NUM_UNITS);
        unit_bytes = int'(fula_pkg::RST_UNIT_SIZE);
        sent       = 0;
        settings   = 1;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        // reset pool: 50 units of 1024 bytes, edges of size and index
        send_request(fula_pkg::CMD_ALLOC, 24'd0,       1'b1, 9'd0);
        send_request(fula_pkg::CMD_ALLOC, 24'd1024,    1'b1, 9'd0);
        send_request(fula_pkg::CMD_ALLOC, 24'd1025,    1'b1, 9'd0);
        send_request(fula_pkg::CMD_ALLOC, 24'hFFFFFF,  1'b1, 9'h1FF);
        send_request(fula_pkg::CMD_ALLOC, 24'd16,      1'b0, 9'd0);
        send_request(fula_pkg::CMD_FREE,  24'd0,       1'b0, 9'd48);
        send_request(fula_pkg::CMD_FREE,  24'd0,       1'b0, 9'd49);
        send_request(fula_pkg::CMD_FREE,  24'd0,       1'b0, 9'd50);
        send_request(fula_pkg::CMD_FREE,  24'hFFFFFF,  1'b1, 9'h1FF);
        send_request(fula_pkg::CMD_FREE,  24'd0,       1'b1, 9'd0);
        send_request(fula_pkg::CMD_ALLOC, 24'd512,     1'b1, 9'd0);
        send_request(fula_pkg::CMD_ALLOC, 24'h800000,  1'b1, 9'd0);
        run_phase(100, PACE_FULL);

        // two-unit pool: run it dry, return one unit and reuse it
        reconfigure(1'b1, 21'd2, 1'b0, '0);
        send_request(fula_pkg::CMD_ALLOC, 24'd1, 1'b1, 9'd0);
        send_request(fula_pkg::CMD_ALLOC, 24'd1, 1'b1, 9'd0);
        send_request(fula_pkg::CMD_ALLOC, 24'd1, 1'b1, 9'd0);
        send_request(fula_pkg::CMD_FREE,  24'd0, 1'b0, 9'd2);
        send_request(fula_pkg::CMD_FREE,  24'd0, 1'b0, 9'd1);
        send_request(fula_pkg::CMD_ALLOC, 24'd0, 1'b1, 9'd0);
        send_request(fula_pkg::CMD_ALLOC, 24'd0, 1'b1, 9'd0);
        run_phase(120, PACE_SEND_GAPS);

        // full storage, largest nominal unit
        reconfigure(1'b1, 21'd256, 1'b1, 21'd1048576);
        run_phase(200, PACE_RECV_STALLS);

        // unit size change alone keeps the list
        reconfigure(1'b0, '0, 1'b1, 21'h1FFFFF);
        run_phase(120, PACE_BOTH);

        // no pool at all
        reconfigure(1'b1, 21'd0, 1'b1, 21'd4096);
        run_phase(80, PACE_FULL);

        // count beyond storage, one-byte units
        reconfigure(1'b1, 21'd511, 1'b1, 21'd1);
        run_phase(150, PACE_SEND_GAPS);

        // single unit, zero-byte units
        reconfigure(1'b1, 21'd1, 1'b1, 21'd0);
        run_phase(100, PACE_RECV_STALLS);

        // upper write bits beyond the count field are dropped
        reconfigure(1'b1, {12'hFFF, 9'd6}, 1'b1, 21'd64);
        run_phase(150, PACE_BOTH);

        reconfigure(1'b1, 21'd16, 1'b1, 21'd256);
        run_phase(150, PACE_FULL);

        reconfigure(1'b1, 21'd257, 1'b1, 21'd512);
        run_phase(170, PACE_RECV_STALLS);

        // wind down
        drain_results();
        stall_pct = 0;
        repeat (10) @(negedge clk);

        $display("covered %0d requests across %0d pool settings with mixed back-pressure",
                 sent, settings);
        $display("outcomes: %0d grants, %0d system allocates, %0d returns, %0d system frees",
                 grant_count, sys_alloc_count, return_count, sys_free_count);
        if (fail_count == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
